FILE: design/pca_projection_engine_assert.svh
// Assertion macros used by the projection engine top level
`ifndef PCA_PROJECTION_ENGINE_ASSERT_SVH
`define PCA_PROJECTION_ENGINE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define PCA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define PCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: design/pca_pkg.sv
// Shared types and constants of the projection engine
package pca_pkg;
	localparam int unsigned MaxFeatures   = 256;
	localparam int unsigned MaxComponents = 64;

	localparam logic [1:0] OpLoadMean   = 2'd0;
	localparam logic [1:0] OpLoadWeight = 2'd1;
	localparam logic [1:0] OpFeature    = 2'd2;
	localparam logic [1:0] OpReserved   = 2'd3;

	localparam logic RegFeatureCount   = 1'b0;
	localparam logic RegComponentCount = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_RUN,
		ST_EMIT
	} state_t;

	// command given to each cell of the row every cycle
	typedef struct packed {
		logic valid;
		logic clear;
	} cell_ctl_t;

	typedef struct packed {
		logic [5:0]  component;
		logic [31:0] score;
		logic        saturated;
		logic        final_res;
	} result_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  feature_index;
		logic [5:0]  component_index;
		logic [31:0] value;
		logic        vector_end;
	} item_t;
endpackage

FILE: design/pca_if.sv
// Valid/ready channels of the projection engine
interface pca_item_if;
	logic           valid;
	logic           ready;
	pca_pkg::item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface pca_result_if;
	logic             valid;
	logic             ready;
	pca_pkg::result_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface pca_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [8:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/pca_projection_engine.sv
// Top level of the projection engine
// A load item writes its memory and leaves the engine ready. A feature item then holds
// the engine busy until the next one can be accepted: the FETCH state reads the mean and
// the first weight, then for a feature index below the feature count the shared multiplier
// delivers one product per cycle through a two-stage pipe and the cell selected by the
// component counter adds it; the pipe then drains. On vector_end the cell row then shifts
// toward cell 0 once per emitted score, one score per accepted result transaction, and the
// last one clears every cell. The weight memory has one read port, which sets the
// one-product-per-cycle figure. No clearing pass is needed.
module pca_projection_engine #(
	parameter int unsigned MAX_FEATURES   = pca_pkg::MaxFeatures,
	parameter int unsigned MAX_COMPONENTS = pca_pkg::MaxComponents
) (
	input logic clk,
	input logic arst_n,
	pca_item_if.sink     in_ch,
	pca_result_if.source out_ch,
	pca_cfg_if.sink      cfg
);
	localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int CNW = $clog2(MAX_COMPONENTS + 1);
	localparam int FNW = $clog2(MAX_FEATURES + 1);
	localparam int WAW = $clog2(MAX_FEATURES * MAX_COMPONENTS);

	logic [31:0] mean_mem [MAX_FEATURES];
	logic [31:0] wt_mem [MAX_FEATURES * MAX_COMPONENTS];

	logic [8:0] fcount_q;
	logic [6:0] ccount_q;
	logic [FNW-1:0] eff_f;
	logic [CNW-1:0] eff_c;

	pca_pkg::state_t state_q, state_d;
	logic [CW-1:0] k_q;       // weight read address counter
	logic [CNW-1:0] left_q;   // products still to issue
	logic [CNW-1:0] emit_q;   // scores still to emit
	logic [5:0] ecomp_q;
	logic [FW-1:0] fi_q;
	logic signed [31:0] val_q;
	logic last_q, use_q;

	logic signed [31:0] mean_s1, wt_s1;
	logic               v_s1;
	logic [CW-1:0]      k_s1;
	logic signed [63:0] prod_s2;
	logic               v_s2;
	logic [CW-1:0]      k_s2;

	pca_pkg::item_t it;
	logic in_fire, out_fire, shift, clear_all;
	logic signed [32:0] diff;
	logic signed [64:0] prod_full;
	logic signed [63:0] add_val;
	logic signed [63:0] acc [MAX_COMPONENTS];
	logic [CNW-1:0] k_ext;

	assign it = in_ch.payload;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		eff_f = (32'(fcount_q) > MAX_FEATURES) ? FNW'(MAX_FEATURES) : FNW'(fcount_q);
		if (fcount_q == 9'd0) eff_f = FNW'(1);
		eff_c = (32'(ccount_q) > MAX_COMPONENTS) ? CNW'(MAX_COMPONENTS) : CNW'(ccount_q);
		if (ccount_q == 7'd0) eff_c = CNW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcount_q <= 9'd256;
			ccount_q <= 7'd64;
		end else if (cfg.valid) begin
			if (cfg.index == pca_pkg::RegFeatureCount) fcount_q <= cfg.data;
			else ccount_q <= cfg.data[6:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && it.op == pca_pkg::OpLoadMean && 32'(it.feature_index) < MAX_FEATURES)
			mean_mem[FW'(it.feature_index)] <= it.value;
		if (in_fire && it.op == pca_pkg::OpLoadWeight
				&& 32'(it.feature_index) < MAX_FEATURES
				&& 32'(it.component_index) < MAX_COMPONENTS)
			wt_mem[WAW'(32'(it.feature_index) * MAX_COMPONENTS + 32'(it.component_index))]
				<= it.value;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pca_pkg::ST_IDLE: if (in_fire && it.op == pca_pkg::OpFeature) state_d = pca_pkg::ST_FETCH;
			pca_pkg::ST_FETCH: state_d = pca_pkg::ST_RUN;
			pca_pkg::ST_RUN: if (left_q == '0 && !v_s1 && !v_s2)
				state_d = last_q ? pca_pkg::ST_EMIT : pca_pkg::ST_IDLE;
			pca_pkg::ST_EMIT: if (out_fire && emit_q == CNW'(1)) state_d = pca_pkg::ST_IDLE;
			default: state_d = pca_pkg::ST_IDLE;
		endcase
	end

	assign in_ch.ready = (state_q == pca_pkg::ST_IDLE);
	assign out_ch.valid = (state_q == pca_pkg::ST_EMIT);
	assign shift = out_fire;
	// the last score of a vector empties the whole row
	assign clear_all = out_fire && (emit_q == CNW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pca_pkg::ST_IDLE;
			left_q <= '0;
			emit_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1 <= (state_q == pca_pkg::ST_RUN) && left_q != '0 && use_q;
			v_s2 <= v_s1;
			if (state_q == pca_pkg::ST_IDLE && in_fire) begin
				left_q <= eff_c;
				emit_q <= eff_c;
			end else if (state_q == pca_pkg::ST_RUN && left_q != '0) begin
				left_q <= left_q - CNW'(1);
			end
			if (out_fire) emit_q <= emit_q - CNW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			fi_q <= FW'(it.feature_index);
			val_q <= it.value;
			last_q <= it.vector_end;
			use_q <= 32'(it.feature_index) < 32'(eff_f);
			k_q <= '0;
			ecomp_q <= '0;
		end
		if (state_q == pca_pkg::ST_FETCH || state_q == pca_pkg::ST_RUN) begin
			mean_s1 <= mean_mem[fi_q];
			wt_s1 <= wt_mem[WAW'(32'(fi_q) * MAX_COMPONENTS + 32'(k_q))];
			k_s1 <= k_q;
			if (state_q == pca_pkg::ST_RUN) k_q <= k_q + CW'(1);
		end
		prod_s2 <= prod_full[63:0];
		k_s2 <= k_s1;
		if (out_fire) ecomp_q <= ecomp_q + 6'd1;
	end

	// first fetch cycle primes the pipe with k = 0; RUN reissues with k advancing
	assign diff = 33'(val_q) - 33'(mean_s1);
	assign prod_full = diff * wt_s1;
	assign add_val = prod_s2 >>> 16;

	genvar g;
	generate
		for (g = 0; g < MAX_COMPONENTS; g++) begin : g_cell
			pca_pkg::cell_ctl_t c;
			assign c.valid = v_s2 && k_s2 == CW'(g);
			assign c.clear = clear_all;
			pca_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(c), .addend(add_val), .shift(shift),
				.shift_in((g == MAX_COMPONENTS - 1) ? 64'sd0 : acc[(g + 1) % MAX_COMPONENTS]),
				.acc(acc[g])
			);
		end
	endgenerate

	always_comb begin
		out_ch.payload.component = ecomp_q;
		out_ch.payload.final_res = (emit_q == CNW'(1));
		out_ch.payload.saturated = 1'b1;
		if (acc[0] > 64'sd2147483647) out_ch.payload.score = 32'h7fffffff;
		else if (acc[0] < -64'sd2147483648) out_ch.payload.score = 32'h80000000;
		else begin
			out_ch.payload.score = acc[0][31:0];
			out_ch.payload.saturated = 1'b0;
		end
	end

	assign k_ext = CNW'(k_s2);

	`include "pca_projection_engine_assert.svh"
	`PCA_ASSERT_IMP(a_no_in_busy, clk, arst_n, state_q != pca_pkg::ST_IDLE, !in_ch.ready)
	`PCA_ASSERT_IMP(a_add_range, clk, arst_n, v_s2, k_ext < eff_c)
	`PCA_ASSERT_IMP(a_out_emit, clk, arst_n, out_ch.valid, emit_q != '0)
	`PCA_ASSERT_NEXT(a_idle_after_final, clk, arst_n,
		out_fire && out_ch.payload.final_res, state_q == pca_pkg::ST_IDLE)
endmodule

FILE: design/pca_cell.sv
// One accumulator cell: adds a shifted product, hands its score down, or clears
module pca_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  pca_pkg::cell_ctl_t  ctl,
	input  logic signed [63:0]  addend,
	input  logic                shift,
	input  logic signed [63:0]  shift_in,
	output logic signed [63:0]  acc
);
	logic signed [63:0] acc_q;
	logic signed [63:0] sum;
	logic               ovf;

	assign sum = acc_q + addend;
	assign ovf = (acc_q[63] == addend[63]) && (sum[63] != acc_q[63]);
	assign acc = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (shift) begin
			acc_q <= shift_in;
		end else if (ctl.valid) begin
			if (ovf) acc_q <= acc_q[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
			else acc_q <= sum;
		end
	end
endmodule
